@@ hdl/ctp_pkg.sv @@
// Shared types and constants for the color-to-palette-index block.
package ctp_pkg;

    localparam int PALETTE_DEPTH = 32;
    localparam int SLOT_W        = $clog2(PALETTE_DEPTH);
    localparam int LIMIT_W       = 6;
    localparam int INDEX_W       = 5;
    localparam int CMP_W         = (SLOT_W > LIMIT_W) ? SLOT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] MAX_COLORS_RESET = LIMIT_W'(32);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       new_image;
    } ctp_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               status;
    } ctp_out_t;

    // Word as it walks down the row of cells.
    typedef struct packed {
        logic [23:0]       color;      // red:green:blue
        logic              new_image;
        logic              done;       // matched or allocated
        logic              ovf;        // palette overflow seen
        logic [SLOT_W-1:0] slot;
    } ctp_item_t;

endpackage

@@ hdl/ctp_cell.sv @@
// One palette entry plus the pipeline stage that follows it.
module ctp_cell
    import ctp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SLOT_W-1:0]  cell_id,
    input  logic [LIMIT_W-1:0] limit,
    input  logic               up_valid,
    input  ctp_item_t          up_item,
    output logic               up_ready,
    output logic               valid,
    output ctp_item_t          item,
    input  logic               down_ready
);

    logic        valid_reg, valid_next;
    ctp_item_t   item_reg;
    logic        entry_valid_reg, entry_valid_next;
    logic [23:0] entry_color_reg;
    logic        blocked_reg, blocked_next;

    logic        move;
    logic        vld_eff;
    logic        blk_eff;
    logic        in_limit;
    logic        is_last;
    logic        alloc;
    ctp_item_t   item_next;

    assign up_ready = !valid_reg || down_ready;
    assign move     = up_valid && up_ready;
    assign vld_eff  = entry_valid_reg && !up_item.new_image;
    assign blk_eff  = blocked_reg && !up_item.new_image;
    assign in_limit = CMP_W'(cell_id) < CMP_W'(limit);
    assign is_last  = cell_id == SLOT_W'(PALETTE_DEPTH - 1);

    always_comb
    begin
        item_next = up_item;
        alloc     = 1'b0;
        if (blk_eff)
        begin
            // overflow already latched for this image
            item_next.ovf = 1'b1;
        end
        else if (!up_item.done && !up_item.ovf)
        begin
            if (vld_eff && entry_color_reg == up_item.color)
            begin
                item_next.done = 1'b1;
                item_next.slot = cell_id;
            end
            else if (!vld_eff)
            begin
                // first free entry
                if (in_limit)
                begin
                    alloc          = 1'b1;
                    item_next.done = 1'b1;
                    item_next.slot = cell_id;
                end
                else
                begin
                    item_next.ovf = 1'b1;
                end
            end
            else if (is_last)
            begin
                item_next.ovf = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next       = valid_reg;
        entry_valid_next = entry_valid_reg;
        blocked_next     = blocked_reg;
        if (move)
        begin
            valid_next       = 1'b1;
            entry_valid_next = vld_eff || alloc;
            blocked_next     = item_next.ovf;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            entry_valid_reg <= 1'b0;
            blocked_reg     <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            entry_valid_reg <= entry_valid_next;
            blocked_reg     <= blocked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            item_reg <= item_next;
        end
        if (move && alloc)
        begin
            entry_color_reg <= up_item.color;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

    a_alloc_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        move && alloc |=> entry_valid_reg)
        else $error("allocated entry not marked valid");

    a_new_image_clears: assert property (@(posedge clk) disable iff (!rst_n)
        move && up_item.new_image && !alloc |=> !entry_valid_reg)
        else $error("new image word left a stale entry");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !down_ready |=> valid_reg && $stable(item_reg))
        else $error("stalled stage lost its word");

endmodule

@@ hdl/color_to_palette_index.sv @@
// Top level: palette builder, one color in and one palette index out per word.
//
// Input channel (in_valid / in_stall / in_data): one pixel word per accepted
// edge, carrying blue, green, red and a new_image flag that empties the
// palette and the overflow status before that pixel is looked up.
// Output channel (out_valid / out_stall / out_data): one word per input word,
// in order, with the palette index and status (1 = palette overflow, index 0).
// Configuration: cfg_wr_en / cfg_wr_data load max_colors; write only while
// no pixel is in flight. Values above the palette depth act as the depth.
// Pipeline: one register per cell; a word passes the registers of the cells in
// order, from cell 0 to the last, before out_valid shows its result.
// Throughput: one word per cycle while out_stall is low; each cell compares the
// passing word with its entry and hands it on, so a new word enters each cycle.
// Stall: a stalled output holds its word; stages behind it keep filling any
// empty slots, and in_stall rises only once every stage holds a word.
// Reset: palette empty, overflow clear, max_colors = 32, no words in flight.
module color_to_palette_index
    import ctp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  ctp_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ctp_out_t           out_data
);

    logic [LIMIT_W-1:0] max_colors_reg;

    // chain of handshake wires, element 0 is the input port side
    logic      chain_valid [PALETTE_DEPTH+1];
    logic      chain_ready [PALETTE_DEPTH+1];
    ctp_item_t chain_item  [PALETTE_DEPTH+1];
    ctp_item_t tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_colors_reg <= MAX_COLORS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_colors_reg <= cfg_wr_data;
        end
    end

    // fresh word: not yet matched, no overflow
    always_comb
    begin
        chain_item[0].color     = {in_data.red, in_data.green, in_data.blue};
        chain_item[0].new_image = in_data.new_image;
        chain_item[0].done      = 1'b0;
        chain_item[0].ovf       = 1'b0;
        chain_item[0].slot      = '0;
    end

    assign chain_valid[0]             = in_valid;
    assign in_stall                   = !chain_ready[0];
    assign chain_ready[PALETTE_DEPTH] = !out_stall;

    for (genvar g = 0; g < PALETTE_DEPTH; g++)
    begin : g_cell
        ctp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_id    (SLOT_W'(g)),
            .limit      (max_colors_reg),
            .up_valid   (chain_valid[g]),
            .up_item    (chain_item[g]),
            .up_ready   (chain_ready[g]),
            .valid      (chain_valid[g+1]),
            .item       (chain_item[g+1]),
            .down_ready (chain_ready[g+1])
        );
    end

    assign tail           = chain_item[PALETTE_DEPTH];
    assign out_valid      = chain_valid[PALETTE_DEPTH];
    assign out_data.index = tail.ovf ? '0 : INDEX_W'(tail.slot);
    assign out_data.status = tail.ovf;

    a_result_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tail.done || tail.ovf)
        else $error("word left the chain without a result");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.status ##1 out_valid && !tail.new_image
        |-> out_data.status)
        else $error("overflow status dropped inside an image");

    a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output was moving");

endmodule
